[sv/seven_segment_two_wire_display_driver_defines.svh]
// Assertion macros for the display driver RTL.
// Included by the bus sequencer, which checks its own sequencing; needs clk and rst_n in scope.
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ssd_pkg.sv]
// Shared types, constants and lookup functions for the two-wire display driver.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssd_pkg;

  localparam int unsigned StepW = 5;
  localparam int unsigned SubW  = 4;
  localparam int unsigned WaitW = 11;

  localparam logic [StepW-1:0] NUM_ELEMS = 5'd20;
  localparam logic [StepW-1:0] IDLE_STEP = 5'd31;

  // Elements of the update sequence that carry a byte.
  localparam logic [StepW-1:0] ELEM_DATA_CMD = 5'd1;
  localparam logic [StepW-1:0] ELEM_ADDR_CMD = 5'd5;
  localparam logic [StepW-1:0] ELEM_LEFT     = 5'd7;
  localparam logic [StepW-1:0] ELEM_HUNDREDS = 5'd9;
  localparam logic [StepW-1:0] ELEM_TENS     = 5'd11;
  localparam logic [StepW-1:0] ELEM_UNITS    = 5'd13;
  localparam logic [StepW-1:0] ELEM_DISP_CTL = 5'd17;

  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hc0;

  localparam logic [7:0] RST_TICKS_PER_US = 8'd1;
  localparam logic [7:0] RST_DISP_CTL     = 8'h8f;
  localparam logic [7:0] RST_LEFT_PATTERN = 8'h25;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_DISP_CTL     = 2'd1;
  localparam logic [1:0] REG_LEFT_PATTERN = 2'd2;

  // Kinds of sequence elements.
  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_BYTE  = 2'd1;
  localparam logic [1:0] K_ACK   = 2'd2;
  localparam logic [1:0] K_STOP  = 2'd3;

  // Delay codes attached to a bus action.
  localparam logic [1:0] DLY_NONE = 2'd0;
  localparam logic [1:0] DLY_2US  = 2'd1;
  localparam logic [1:0] DLY_3US  = 2'd2;
  localparam logic [1:0] DLY_5US  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] value;
    logic        dio_in;
  } ssd_item_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic dio_drive;
    logic busy_res;
  } ssd_res_t;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] display_control;
    logic [7:0] left_pattern;
  } ssd_cfg_t;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [SubW-1:0]  sub;
    logic [7:0]       shift;
    logic             clk_lvl;
    logic             data_lvl;
    logic             drive;
  } ssd_seq_t;

  typedef struct packed {
    ssd_seq_t   st;
    logic [1:0] dly;
    logic       chain;
  } ssd_act_t;

  function automatic logic [7:0] seg_lut(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      4'hf: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] elem_kind(input logic [StepW-1:0] step);
    logic [1:0] k;
    unique case (step)
      5'd0, 5'd4, 5'd16: k = K_START;
      5'd1, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd17: k = K_BYTE;
      5'd2, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd18: k = K_ACK;
      default: k = K_STOP;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/ssd_digits.sv]
// Decimal digit splitter and segment store: one divide-by-ten step per cycle.
// Depends on ssd_pkg for the segment lookup.
`default_nettype none

module ssd_digits import ssd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [15:0]     value,
  output logic [2:0][7:0] segs
);

  logic [15:0]     rem_r, rem_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0][7:0] segs_r;
  logic [31:0]     prod;
  logic [12:0]     quot;
  logic [15:0]     diff;
  logic [1:0]      wr_idx;

  // x / 10 == (x * 0xCCCD) >> 19 holds for every 16-bit x.
  assign prod   = rem_r * 32'd52429;
  assign quot   = prod[31:19];
  assign diff   = rem_r - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign wr_idx = cnt_r - 2'd1;

  always_comb begin
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = value;
      cnt_nxt = 2'd3;
    end else if (cnt_r != 2'd0) begin
      rem_nxt = {3'b000, quot};
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Units land in entry 2, tens in entry 1, hundreds in entry 0.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (!start && cnt_r != 2'd0) begin
      segs_r[wr_idx] <= seg_lut(diff[3:0]);
    end
  end

  assign segs = segs_r;

endmodule

`default_nettype wire

[sv/ssd_seq.sv]
// Bus sequencer: start, byte, acknowledge and stop elements driven tick by tick.
// Depends on ssd_pkg and the assertion macro header.
`default_nettype none

`include "seven_segment_two_wire_display_driver_defines.svh"

module ssd_seq import ssd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  ssd_item_t       item,
  input  ssd_cfg_t        cfg,
  input  logic [2:0][7:0] segs,
  output logic            load_go,
  output ssd_res_t        res_nxt
);

  ssd_seq_t         st_r, st_nxt, base;
  logic [WaitW-1:0] wait_r, wait_nxt, wait_dec, tpu, dly_ticks;
  ssd_act_t         a1, a2;
  logic             busy, run_en;

  function automatic logic [7:0] byte_for(input logic [StepW-1:0] step,
                                          input ssd_cfg_t c,
                                          input logic [2:0][7:0] sg);
    logic [7:0] b;
    unique case (step)
      ELEM_DATA_CMD: b = CMD_DATA;
      ELEM_ADDR_CMD: b = CMD_ADDR;
      ELEM_LEFT:     b = c.left_pattern;
      ELEM_HUNDREDS: b = sg[0];
      ELEM_TENS:     b = sg[1];
      ELEM_UNITS:    b = sg[2];
      ELEM_DISP_CTL: b = c.display_control;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

  // One bus action at the current element and sub-step. A zero-delay action
  // that moves on to a further element asks for a chained action.
  function automatic ssd_act_t act(input ssd_seq_t s, input logic dio,
                                   input logic [7:0] bv);
    ssd_act_t   a;
    logic [7:0] sh;
    logic       adv;
    a       = '{st: s, dly: DLY_NONE, chain: 1'b0};
    sh      = (s.sub == '0) ? bv : s.shift;
    adv     = 1'b0;
    unique case (elem_kind(s.step))
      K_START: begin
        if (s.sub == '0) begin
          a.st.drive    = 1'b1;
          a.st.clk_lvl  = 1'b1;
          a.st.data_lvl = 1'b1;
          a.dly         = DLY_2US;
          a.st.sub      = 4'd1;
        end else begin
          a.st.data_lvl = 1'b0;
          adv           = 1'b1;
        end
      end
      K_BYTE: begin
        if (!s.sub[0]) begin
          if (s.sub == '0) begin
            a.st.drive = 1'b1;
          end
          a.st.shift    = sh;
          a.st.clk_lvl  = 1'b0;
          a.st.data_lvl = sh[0];
          a.dly         = DLY_3US;
          a.st.sub      = s.sub + 4'd1;
        end else begin
          a.st.shift   = {1'b0, s.shift[7:1]};
          a.st.clk_lvl = 1'b1;
          a.dly        = DLY_3US;
          if (s.sub == 4'd15) begin
            adv = 1'b1;
          end else begin
            a.st.sub = s.sub + 4'd1;
          end
        end
      end
      K_ACK: begin
        if (s.sub == 4'd0) begin
          a.st.drive   = 1'b0;
          a.st.clk_lvl = 1'b0;
          a.dly        = DLY_5US;
          a.st.sub     = 4'd1;
        end else if (s.sub == 4'd1) begin
          if (!dio) begin
            a.st.clk_lvl = 1'b1;
            a.dly        = DLY_2US;
            a.st.sub     = 4'd2;
          end
        end else begin
          a.st.clk_lvl = 1'b0;
          adv          = 1'b1;
        end
      end
      K_STOP: begin
        if (s.sub == 4'd0) begin
          a.st.drive   = 1'b1;
          a.st.clk_lvl = 1'b0;
          a.dly        = DLY_2US;
          a.st.sub     = 4'd1;
        end else if (s.sub == 4'd1) begin
          a.st.data_lvl = 1'b0;
          a.dly         = DLY_2US;
          a.st.sub      = 4'd2;
        end else if (s.sub == 4'd2) begin
          a.st.clk_lvl = 1'b1;
          a.dly        = DLY_2US;
          a.st.sub     = 4'd3;
        end else begin
          a.st.data_lvl = 1'b1;
          adv           = 1'b1;
        end
      end
      default: a = a;
    endcase
    if (adv) begin
      a.st.sub = '0;
      if (s.step >= NUM_ELEMS - 5'd1) begin
        a.st.step = IDLE_STEP;
      end else begin
        a.st.step = s.step + 5'd1;
        a.chain   = (a.dly == DLY_NONE);
      end
    end
    return a;
  endfunction

  assign busy     = (st_r.step != IDLE_STEP);
  assign wait_dec = (wait_r != '0) ? wait_r - 11'd1 : '0;
  assign load_go  = fire && item.op && !busy;
  assign run_en   = load_go || (fire && !item.op && busy && wait_dec == '0);
  assign tpu      = (cfg.ticks_per_us == 8'd0) ? 11'd1 : {3'b000, cfg.ticks_per_us};

  always_comb begin
    base = st_r;
    if (load_go) begin
      base.step = '0;
      base.sub  = '0;
    end
    a1 = act(base, item.dio_in, byte_for(base.step, cfg, segs));
    a2 = a1.chain ? act(a1.st, item.dio_in, byte_for(a1.st.step, cfg, segs)) : a1;
  end

  always_comb begin
    unique case (a2.dly)
      DLY_2US: dly_ticks = {tpu[9:0], 1'b0};
      DLY_3US: dly_ticks = {tpu[9:0], 1'b0} + tpu;
      DLY_5US: dly_ticks = {tpu[8:0], 2'b00} + tpu;
      default: dly_ticks = '0;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    wait_nxt = wait_r;
    if (fire && !item.op && busy) begin
      wait_nxt = wait_dec;
    end
    if (load_go) begin
      wait_nxt = '0;
    end
    if (run_en) begin
      st_nxt = a2.st;
      if (a2.dly != DLY_NONE) begin
        wait_nxt = dly_ticks;
      end
    end
  end

  assign res_nxt = '{clk_out:   st_nxt.clk_lvl,
                     dio_out:   st_nxt.data_lvl,
                     dio_drive: st_nxt.drive,
                     busy_res:  (st_nxt.step != IDLE_STEP)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '{step: IDLE_STEP, sub: '0, shift: '0,
                  clk_lvl: 1'b1, data_lvl: 1'b1, drive: 1'b1};
      wait_r <= '0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
  end

  `SSD_ASSERT_SAME(a_idle_bus_released, !busy,
                   st_r.clk_lvl && st_r.data_lvl && st_r.drive,
                   "bus lines not high while idle")
  `SSD_ASSERT_SAME(a_release_only_in_ack, !st_r.drive,
                   busy && elem_kind(st_r.step) == K_ACK,
                   "data line released outside an acknowledge")
  `SSD_ASSERT_NEXT(a_wait_holds_step, fire && !item.op && wait_r > 11'd1,
                   $stable(st_r.step) && $stable(st_r.sub),
                   "sequence advanced before its delay ran out")
  `SSD_ASSERT_NEXT(a_load_starts, load_go, st_r.step == '0 && st_r.sub == 4'd1,
                   "load while idle did not start a sequence")

endmodule

`default_nettype wire

[sv/seven_segment_two_wire_display_driver.sv]
// A transaction accepted into the input register is processed when it fires, which loads the
// output register, from which its result is taken. Throughput: one transaction per cycle
// unless out_stall holds the output; stalls pass back from out_stall through one stage.
// Reset (synchronous, rst_n low): sequencer idle with all bus lines high and driven,
// registers back to their defaults; digit segments stay unknown until a load writes them.
`default_nettype none

module seven_segment_two_wire_display_driver import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_value,
  input  logic        in_dio_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_clk_out,
  output logic        out_dio_out,
  output logic        out_dio_drive,
  output logic        out_busy_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  ssd_cfg_t        cfg_r;
  ssd_item_t       s1_item_r;
  logic            s1_vld_r, s1_vld_nxt;
  ssd_res_t        s2_res_r, res_nxt;
  logic            s2_vld_r, s2_vld_nxt;
  logic            fire, in_take, load_go;
  logic [2:0][7:0] segs;

  assign fire     = s1_vld_r && (!s2_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end
    s2_vld_nxt = s2_vld_r;
    if (fire) begin
      s2_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      s2_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      cfg_r    <= '{ticks_per_us: RST_TICKS_PER_US,
                    display_control: RST_DISP_CTL,
                    left_pattern: RST_LEFT_PATTERN};
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICKS_PER_US: cfg_r.ticks_per_us    <= cfg_wdata;
          REG_DISP_CTL:     cfg_r.display_control <= cfg_wdata;
          REG_LEFT_PATTERN: cfg_r.left_pattern    <= cfg_wdata;
          default:          cfg_r                 <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{op: in_op, value: in_value, dio_in: in_dio_in};
    end
    if (fire) begin
      s2_res_r <= res_nxt;
    end
  end

  ssd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .segs    (segs),
    .load_go (load_go),
    .res_nxt (res_nxt)
  );

  ssd_digits u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_go),
    .value (s1_item_r.value),
    .segs  (segs)
  );

  assign out_valid     = s2_vld_r;
  assign out_clk_out   = s2_res_r.clk_out;
  assign out_dio_out   = s2_res_r.dio_out;
  assign out_dio_drive = s2_res_r.dio_drive;
  assign out_busy_res  = s2_res_r.busy_res;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the two-wire seven-segment display driver.
// Sends load and tick transactions with random pacing and back-pressure, predicts the bus
// levels of every transaction and compares each result; needs ssd_pkg and the driver RTL.
module tb_top;
  import ssd_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_ITEMS  = 50;
  localparam int END_CYCLES  = 8;
  localparam int SLOW_TICKS  = 30;

  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_TICK;
  logic [15:0] in_value = '0;
  logic        in_dio_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_clk_out;
  logic        out_dio_out;
  logic        out_dio_drive;
  logic        out_busy_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TICKS_PER_US;
  logic [7:0]  cfg_wdata = '0;

  seven_segment_two_wire_display_driver dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_dio_in    (in_dio_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_clk_out  (out_clk_out),
    .out_dio_out  (out_dio_out),
    .out_dio_drive(out_dio_drive),
    .out_busy_res (out_busy_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor copy of the configuration registers.
  logic [7:0] us_ticks = RST_TICKS_PER_US;
  logic [7:0] ctl_byte = RST_DISP_CTL;
  logic [7:0] left_seg = RST_LEFT_PATTERN;

  // Predictor copy of the bus sequencer.
  logic [4:0] frame_pos = IDLE_STEP;
  logic [3:0] phase_cnt = '0;
  int         delay_left = 0;
  logic [7:0] out_byte = '0;
  logic [7:0] seg_bytes [3];
  logic       scl_lvl = 1'b1;
  logic       sda_lvl = 1'b1;
  logic       sda_en = 1'b1;

  ssd_res_t expected_levels [$];

  int mismatches = 0;
  int results_checked = 0;
  int updates_started = 0;
  int loads_ignored = 0;
  int ticks_seen = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    case (d)
      4'd0: return 8'h3f;
      4'd1: return 8'h06;
      4'd2: return 8'h5b;
      4'd3: return 8'h4f;
      4'd4: return 8'h66;
      4'd5: return 8'h6d;
      4'd6: return 8'h7d;
      4'd7: return 8'h07;
      4'd8: return 8'h7f;
      default: return 8'h6f;
    endcase
  endfunction

  // Three frames: each opens with a start and closes with a stop; in between,
  // odd positions carry bytes and even positions their acknowledges.
  function automatic logic [1:0] elem_kind_at(input logic [4:0] pos);
    if (pos == 5'd0 || pos == 5'd4 || pos == 5'd16) return K_START;
    if (pos == 5'd3 || pos == 5'd15 || pos == 5'd19) return K_STOP;
    return pos[0] ? K_BYTE : K_ACK;
  endfunction

  function automatic logic [7:0] byte_at(input logic [4:0] pos);
    case (pos)
      ELEM_DATA_CMD: return CMD_DATA;
      ELEM_ADDR_CMD: return CMD_ADDR;
      ELEM_LEFT:     return left_seg;
      ELEM_HUNDREDS: return seg_bytes[0];
      ELEM_TENS:     return seg_bytes[1];
      ELEM_UNITS:    return seg_bytes[2];
      ELEM_DISP_CTL: return ctl_byte;
      default:       return 8'h00;
    endcase
  endfunction

  task automatic advance_elem();
    frame_pos = frame_pos + 5'd1;
    phase_cnt = '0;
    if (frame_pos >= NUM_ELEMS) frame_pos = IDLE_STEP;
  endtask

  // Takes bus actions until one needs a delay, the acknowledge is still
  // pending, or the last frame is done.
  task automatic bus_walk(input logic dio);
    logic [1:0] kind;
    logic [3:0] ph;
    int         us;
    bit         parked;
    parked = 1'b0;
    while (!parked && frame_pos < NUM_ELEMS) begin
      kind = elem_kind_at(frame_pos);
      ph = phase_cnt;
      us = 0;
      case (kind)
        K_START: begin
          if (ph == 4'd0) begin
            sda_en = 1'b1;
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
            us = 2;
            phase_cnt = 4'd1;
          end else begin
            sda_lvl = 1'b0;
            advance_elem();
          end
        end
        K_BYTE: begin
          if (!ph[0]) begin
            if (ph == 4'd0) begin
              out_byte = byte_at(frame_pos);
              sda_en = 1'b1;
            end
            scl_lvl = 1'b0;
            sda_lvl = out_byte[0];
            us = 3;
            phase_cnt = ph + 4'd1;
          end else begin
            out_byte = out_byte >> 1;
            scl_lvl = 1'b1;
            us = 3;
            if (ph == 4'd15) advance_elem();
            else phase_cnt = ph + 4'd1;
          end
        end
        K_ACK: begin
          if (ph == 4'd0) begin
            sda_en = 1'b0;
            scl_lvl = 1'b0;
            us = 5;
            phase_cnt = 4'd1;
          end else if (ph == 4'd1) begin
            // The display acknowledges by pulling the data line low; until then we wait.
            if (dio) begin
              parked = 1'b1;
            end else begin
              scl_lvl = 1'b1;
              us = 2;
              phase_cnt = 4'd2;
            end
          end else begin
            scl_lvl = 1'b0;
            advance_elem();
          end
        end
        default: begin
          if (ph == 4'd0) begin
            sda_en = 1'b1;
            scl_lvl = 1'b0;
            us = 2;
            phase_cnt = 4'd1;
          end else if (ph == 4'd1) begin
            sda_lvl = 1'b0;
            us = 2;
            phase_cnt = 4'd2;
          end else if (ph == 4'd2) begin
            scl_lvl = 1'b1;
            us = 2;
            phase_cnt = 4'd3;
          end else begin
            sda_lvl = 1'b1;
            advance_elem();
          end
        end
      endcase
      if (us != 0) begin
        delay_left = us * ((us_ticks == 8'd0) ? 1 : int'(us_ticks));
        parked = 1'b1;
      end
    end
  endtask

  task automatic predict_levels(input logic op, input logic [15:0] value, input logic dio,
                                output ssd_res_t lv);
    logic was_busy;
    was_busy = frame_pos < NUM_ELEMS;
    if (op == OP_LOAD) begin
      if (!was_busy) begin
        seg_bytes[0] = digit_seg(4'((value / 100) % 10));
        seg_bytes[1] = digit_seg(4'((value / 10) % 10));
        seg_bytes[2] = digit_seg(4'(value % 10));
        frame_pos = '0;
        phase_cnt = '0;
        delay_left = 0;
        updates_started++;
        bus_walk(dio);
      end else begin
        loads_ignored++;
      end
    end else begin
      ticks_seen++;
      if (was_busy) begin
        if (delay_left > 0) delay_left--;
        if (delay_left == 0) bus_walk(dio);
      end
    end
    lv.clk_out = scl_lvl;
    lv.dio_out = sda_lvl;
    lv.dio_drive = sda_en;
    lv.busy_res = frame_pos < NUM_ELEMS;
  endtask

  always @(posedge clk) begin : predict_inputs
    ssd_res_t lv;
    if (rst_n && in_valid && !in_stall) begin
      predict_levels(in_op, in_value, in_dio_in, lv);
      expected_levels.push_back(lv);
    end
  end

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    $display("[%0t] result %0d: %s is %b, expected %b", $time, results_checked, what, got,
             want);
  endtask

  always @(posedge clk) begin : check_results
    ssd_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("out_valid with nothing pending", 1'b1, 1'b0);
      end else begin
        want = expected_levels.pop_front();
        if (out_clk_out !== want.clk_out) report_mismatch("clk_out", out_clk_out, want.clk_out);
        if (out_dio_out !== want.dio_out) report_mismatch("dio_out", out_dio_out, want.dio_out);
        if (out_dio_drive !== want.dio_drive)
          report_mismatch("dio_drive", out_dio_drive, want.dio_drive);
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", out_busy_res, want.busy_res);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results still pending.",
               QUIET_LIMIT, expected_levels.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: switches among random stall patterns and honors long hold requests.
  initial begin : receiver
    int cyc;
    int mode;
    cyc = 0;
    mode = STALL_NONE;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= ((cyc % 9) < 4);
          default:        out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_item(input logic op, input logic [15:0] value, input logic dio);
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= value;
    in_dio_in <= dio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pacing: bursts of random length separated by short gaps, with the
  // occasional long burst.
  task automatic offer_item(input logic op, input logic [15:0] value, input logic dio);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 12);
    end
    burst_left--;
    send_item(op, value, dio);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_levels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TICKS_PER_US: us_ticks = data;
      REG_DISP_CTL:     ctl_byte = data;
      default:          left_seg = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd999;
      3: return 16'd1000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Ticks until the update is over. Loads while busy and mid-stream drains are mixed in,
  // and a high data line now and then stretches an acknowledge.
  task automatic finish_update();
    while (frame_pos < NUM_ELEMS) begin
      if ($urandom_range(0, 49) == 0)
        offer_item(OP_LOAD, pick_value(), 1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 149) == 0) drain_results();
      else offer_item(OP_TICK, 16'($urandom()), ($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic test_idle_and_busy_loads();
    offer_item(OP_TICK, 16'h0000, 1'b0);
    offer_item(OP_TICK, 16'hffff, 1'b1);
    offer_item(OP_LOAD, 16'hffff, 1'b1);
    offer_item(OP_LOAD, 16'h0000, 1'b0);
    offer_item(OP_TICK, 16'h5555, 1'b1);
    offer_item(OP_TICK, 16'haaaa, 1'b0);
    offer_item(OP_LOAD, 16'd1234, 1'b1);
    repeat (6) offer_item(OP_TICK, 16'h0000, 1'b0);
    finish_update();
  endtask

  task automatic test_register_extremes();
    drain_results();
    // A zero tick rate behaves as one tick per microsecond.
    write_reg(REG_TICKS_PER_US, 8'd0);
    write_reg(REG_DISP_CTL, 8'h00);
    write_reg(REG_LEFT_PATTERN, 8'hff);
    offer_item(OP_LOAD, 16'd0, 1'b0);
    finish_update();
    drain_results();
    write_reg(REG_TICKS_PER_US, 8'd1);
  endtask

  task automatic test_output_hold();
    drain_results();
    write_reg(REG_DISP_CTL, 8'($urandom()));
    write_reg(REG_LEFT_PATTERN, 8'($urandom()));
    offer_item(OP_LOAD, pick_value(), 1'b0);
    // The sender keeps offering while the receiver is held off, so the block backs up.
    hold_request = 1'b1;
    repeat (HOLD_ITEMS) offer_item(OP_TICK, 16'($urandom()), ($urandom_range(0, 3) == 0));
  endtask

  task automatic test_slow_bus();
    drain_results();
    write_reg(REG_TICKS_PER_US, 8'd255);
    write_reg(REG_DISP_CTL, 8'($urandom()));
    offer_item(OP_LOAD, 16'd1000, 1'b0);
    repeat (SLOW_TICKS) begin
      if ($urandom_range(0, 49) == 0)
        offer_item(OP_LOAD, pick_value(), 1'($urandom_range(0, 1)));
      else offer_item(OP_TICK, 16'($urandom()), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_and_busy_loads();
    test_register_extremes();
    test_output_hold();
    test_slow_bus();
    drain_results();
    repeat (END_CYCLES) @(negedge clk);
    $display("Ran %0d display updates, %0d ignored loads and %0d ticks; %0d results checked.",
             updates_started, loads_ignored, ticks_seen, results_checked);
    $display("Tick rates 0, 1 and 255, reset and extreme command bytes, %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
